// File: sv/jpeg2000_comment_stripper_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef JPEG2000_COMMENT_STRIPPER_UNIT_MACROS_SVH
`define JPEG2000_COMMENT_STRIPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/jcs_pkg.sv
package jcs_pkg;

    // Marker bytes of the codestream
    localparam logic [7:0] MARK_PREFIX = 8'hff;
    localparam logic [7:0] MARK_SOC    = 8'h4f;
    localparam logic [7:0] MARK_SOT    = 8'h90;
    localparam logic [7:0] MARK_EOC    = 8'hd9;
    localparam logic [7:0] MARK_COM    = 8'h64;

    // Scan phase codes; the unused code behaves as PHASE_DONE
    localparam logic [1:0] PHASE_SEARCH = 2'd0;
    localparam logic [1:0] PHASE_HEADER = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    localparam int DELAY_DEPTH = 3;
    localparam int MAX_RESULTS = 4;
    localparam int DROP_W      = 17;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_stream;
    } result_t;

endpackage

// File: sv/jcs_in_if.sv
interface jcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: sv/jcs_out_if.sv
interface jcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_stream;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_stream, output ready);
endinterface

// File: sv/jpeg2000_comment_stripper_unit.sv
// JPEG 2000 comment stripper.
// data_in carries the codestream one byte per request, last_byte on the final
// byte. data_out returns the same stream with the first COM segment (FF 64,
// its length field and body) removed, once FF 4F has been seen and before
// FF 90 or FF D9. A three-byte delay line provides the lookahead, so output
// trails input by three bytes; a byte request in mid-stream gives zero or one
// result, the final request gives one to four (the delay line is flushed, or
// one empty result with byte_valid low marks the end).
// Latency: a result is presented the cycle after the request that caused it.
// Throughput: one byte per cycle while the receiver takes each result, set by
// the single result buffer that is drained and reloaded in the same cycle;
// after a final byte the input waits until its last result leaves.
// Reset clears the scan phase, delay line and drop counter; the same happens
// after every final byte. When the receiver stalls, the pending result holds
// and data_in.ready stays low until the last pending result is taken.
module jpeg2000_comment_stripper_unit (
    input  logic             clk,
    input  logic             rst_n,
    jcs_in_if.sink           data_in,
    jcs_out_if.source        data_out
);

    // Stream state
    logic [1:0]                  phase_reg, phase_next;
    logic [7:0]                  dly_reg [jcs_pkg::DELAY_DEPTH];
    logic [7:0]                  dly_next [jcs_pkg::DELAY_DEPTH];
    logic [1:0]                  cnt_reg, cnt_next;
    logic [jcs_pkg::DROP_W-1:0]  drop_reg, drop_next;

    // Result buffer
    jcs_pkg::result_t            res_reg [jcs_pkg::MAX_RESULTS];
    jcs_pkg::result_t            res_next [jcs_pkg::MAX_RESULTS];
    logic [2:0]                  left_reg;
    logic [1:0]                  idx_reg;
    logic [2:0]                  res_cnt;

    // Step intermediates
    logic [7:0]                  cand_byte [jcs_pkg::MAX_RESULTS];
    logic                        cand_en   [jcs_pkg::MAX_RESULTS];
    logic [jcs_pkg::DROP_W-1:0]  drop_work;
    logic [1:0]                  phase_work;
    logic [7:0]                  shift_dly [jcs_pkg::DELAY_DEPTH];
    logic [1:0]                  shift_cnt;
    logic                        searching;
    logic                        in_fire;
    logic                        out_fire;

    assign in_fire  = data_in.valid && data_in.ready;
    assign out_fire = data_out.valid && data_out.ready;

    // Accept a new byte when the buffer is empty or its last result leaves now
    assign data_in.ready = (left_reg == 3'd0) || (left_reg == 3'd1 && data_out.ready);

    assign data_out.valid         = (left_reg != 3'd0);
    assign data_out.out_byte      = res_reg[idx_reg].out_byte;
    assign data_out.byte_valid    = res_reg[idx_reg].byte_valid;
    assign data_out.end_of_stream = res_reg[idx_reg].end_of_stream;

    assign searching = (phase_reg == jcs_pkg::PHASE_SEARCH)
                    || (phase_reg == jcs_pkg::PHASE_HEADER);

    // Process one byte: marker detection, delay line shift, drop and flush
    always_comb
    begin
        drop_work  = drop_reg;
        phase_work = phase_reg;
        shift_dly  = dly_reg;
        shift_cnt  = cnt_reg;

        // Look for a marker at the oldest byte of a full delay line
        if (cnt_reg == 2'd3 && drop_reg == '0 && searching
            && dly_reg[0] == jcs_pkg::MARK_PREFIX)
        begin
            priority if (dly_reg[1] == jcs_pkg::MARK_SOC)
            begin
                phase_work = jcs_pkg::PHASE_HEADER;
            end
            else if (dly_reg[1] == jcs_pkg::MARK_SOT || dly_reg[1] == jcs_pkg::MARK_EOC)
            begin
                phase_work = jcs_pkg::PHASE_DONE;
            end
            else if (phase_reg == jcs_pkg::PHASE_HEADER && dly_reg[1] == jcs_pkg::MARK_COM)
            begin
                drop_work  = jcs_pkg::DROP_W'({1'b0, dly_reg[2], data_in.data_byte})
                           + jcs_pkg::DROP_W'(2);
                phase_work = jcs_pkg::PHASE_DONE;
            end
        end

        // Shift the delay line or fill it
        if (cnt_reg == 2'd3)
        begin
            shift_dly[0] = dly_reg[1];
            shift_dly[1] = dly_reg[2];
            shift_dly[2] = data_in.data_byte;
        end
        else
        begin
            shift_dly[cnt_reg] = data_in.data_byte;
            shift_cnt          = cnt_reg + 2'd1;
        end

        // Candidate bytes in output order: the byte leaving the line, then the flush
        cand_byte[0] = dly_reg[0];
        cand_en[0]   = (cnt_reg == 2'd3);
        for (int k = 0; k < jcs_pkg::DELAY_DEPTH; k++)
        begin
            cand_byte[k+1] = shift_dly[k];
            cand_en[k+1]   = data_in.last_byte && (2'(k) < shift_cnt);
        end

        // Drop or pass each candidate
        res_cnt = 3'd0;
        for (int k = 0; k < jcs_pkg::MAX_RESULTS; k++)
        begin
            res_next[k] = '0;
        end
        for (int k = 0; k < jcs_pkg::MAX_RESULTS; k++)
        begin
            if (cand_en[k])
            begin
                if (drop_work != '0)
                begin
                    drop_work = drop_work - jcs_pkg::DROP_W'(1);
                end
                else
                begin
                    res_next[res_cnt[1:0]].out_byte   = cand_byte[k];
                    res_next[res_cnt[1:0]].byte_valid = 1'b1;
                    res_cnt = res_cnt + 3'd1;
                end
            end
        end

        // Mark the end of the stream and return to the reset state
        if (data_in.last_byte)
        begin
            if (res_cnt == 3'd0)
            begin
                res_cnt = 3'd1;
            end
            res_next[2'(res_cnt - 3'd1)].end_of_stream = 1'b1;
            phase_next = jcs_pkg::PHASE_SEARCH;
            cnt_next   = 2'd0;
            drop_next  = '0;
            for (int k = 0; k < jcs_pkg::DELAY_DEPTH; k++)
            begin
                dly_next[k] = 8'd0;
            end
        end
        else
        begin
            phase_next = phase_work;
            cnt_next   = shift_cnt;
            drop_next  = drop_work;
            dly_next   = shift_dly;
        end
    end

    // Advance stream state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jcs_pkg::PHASE_SEARCH;
            cnt_reg   <= 2'd0;
            drop_reg  <= '0;
            for (int k = 0; k < jcs_pkg::DELAY_DEPTH; k++)
            begin
                dly_reg[k] <= 8'd0;
            end
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            dly_reg   <= dly_next;
        end
    end

    // Hold results until taken; load a new set on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 3'd0;
            idx_reg  <= 2'd0;
        end
        else if (in_fire)
        begin
            left_reg <= res_cnt;
            idx_reg  <= 2'd0;
        end
        else if (out_fire)
        begin
            left_reg <= left_reg - 3'd1;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: sv/jcs_checker.sv
`include "jpeg2000_comment_stripper_unit_macros.svh"

module jcs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_byte_valid,
    input logic out_eos
);

    // A stalled result stays offered
    `JCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // An empty result only marks the end of a stream
    `JCS_ASSERT_NOW(a_empty_is_end, clk, rst_n, out_valid && !out_byte_valid, out_eos, "empty result without end of stream")

    // The final byte always yields a result on the next cycle
    `JCS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_valid && in_ready && in_last, out_valid, "final byte gave no result")

    // Input is held back only while results are pending
    `JCS_ASSERT_NOW(a_stall_reason, clk, rst_n, !in_ready, out_valid, "input stalled with no pending result")

endmodule

bind jpeg2000_comment_stripper_unit jcs_checker u_jcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (data_in.valid),
    .in_ready       (data_in.ready),
    .in_last        (data_in.last_byte),
    .out_valid      (data_out.valid),
    .out_ready      (data_out.ready),
    .out_byte_valid (data_out.byte_valid),
    .out_eos        (data_out.end_of_stream)
);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int RAND_ITEMS = 120;
    localparam int DRAIN_CYCLES = 10;

    // One row of the directed table; exp_typed marks a row whose single result
    // is written out here instead of being taken from the predictor
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last_byte;
        logic             exp_typed;
        jcs_pkg::result_t exp_res;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // one-byte stream, all zeros
        {8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
        // comment marker ahead of the header marker passes through
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_COM,    1'b0, 1'b0, 10'h0},
        {8'h00,                1'b0, 1'b0, 10'h0},
        {8'h11,                1'b1, 1'b0, 10'h0},
        // header, then a short comment that gets removed
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_SOC,    1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_COM,    1'b0, 1'b0, 10'h0},
        {8'h00,                1'b0, 1'b0, 10'h0},
        {8'h02,                1'b0, 1'b0, 10'h0},
        {8'hcd,                1'b0, 1'b0, 10'h0},
        {8'hef,                1'b1, 1'b0, 10'h0},
        // comment runs past the end; final request yields only the end marker
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_SOC,    1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_COM,    1'b0, 1'b0, 10'h0},
        {8'h01,                1'b0, 1'b0, 10'h0},
        {8'h00,                1'b0, 1'b0, 10'h0},
        {8'h11,                1'b0, 1'b0, 10'h0},
        {8'h22,                1'b0, 1'b0, 10'h0},
        {8'h33,                1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
        // three-byte stream is too short to be scanned
        {jcs_pkg::MARK_PREFIX, 1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_SOC,    1'b0, 1'b0, 10'h0},
        {jcs_pkg::MARK_PREFIX, 1'b1, 1'b0, 10'h0}
    };

    logic clk;
    logic rst_n;

    jcs_in_if  in_if ();
    jcs_out_if out_if ();

    jpeg2000_comment_stripper_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (in_if),
        .data_out (out_if)
    );

    // Predictor state
    logic [1:0]       hdr_phase;
    logic [7:0]       window [3];
    int               window_fill;
    logic [16:0]      skip_left;
    jcs_pkg::result_t step_out [$];

    // Expected stripped output, oldest first
    jcs_pkg::result_t stripped_q [$];

    int               fail_count;
    int               src_idle_pct;
    int               snk_idle_pct;
    int               rand_sent;
    logic [7:0]       burst [$];

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_predictor();
        hdr_phase = jcs_pkg::PHASE_SEARCH;
        window = '{default: 8'h00};
        window_fill = 0;
        skip_left = '0;
    endfunction

    // Drop the byte if a comment is being removed, else emit it
    function automatic void pass_or_skip(input logic [7:0] b);
        if (skip_left != 0)
            skip_left = skip_left - 17'd1;
        else
            step_out.push_back({b, 1'b1, 1'b0});
    endfunction

    // Advance the stripper model by one byte; results land in step_out
    function automatic void strip_step(input logic [7:0] b, input logic fin);
        logic [7:0] w0, w1, w2;
        int k;
        step_out.delete();
        if (window_fill == jcs_pkg::DELAY_DEPTH)
        begin
            w0 = window[0];
            w1 = window[1];
            w2 = window[2];
            if (skip_left == 0 && w0 == jcs_pkg::MARK_PREFIX &&
                (hdr_phase == jcs_pkg::PHASE_SEARCH || hdr_phase == jcs_pkg::PHASE_HEADER))
            begin
                if (w1 == jcs_pkg::MARK_SOC)
                    hdr_phase = jcs_pkg::PHASE_HEADER;
                else if (w1 == jcs_pkg::MARK_SOT || w1 == jcs_pkg::MARK_EOC)
                    hdr_phase = jcs_pkg::PHASE_DONE;
                else if (hdr_phase == jcs_pkg::PHASE_HEADER && w1 == jcs_pkg::MARK_COM)
                begin
                    skip_left = {1'b0, w2, b} + 17'd2;
                    hdr_phase = jcs_pkg::PHASE_DONE;
                end
            end
            pass_or_skip(w0);
            window[0] = w1;
            window[1] = w2;
            window[2] = b;
        end
        else
        begin
            window[window_fill] = b;
            window_fill++;
        end
        // flush the delay line on the final byte
        if (fin)
        begin
            for (k = 0; k < window_fill; k++)
                pass_or_skip(window[k]);
            if (step_out.size() == 0)
                step_out.push_back({8'h00, 1'b0, 1'b0});
            step_out[step_out.size() - 1].end_of_stream = 1'b1;
            clear_predictor();
        end
    endfunction

    // Present one byte, wait for the request to be taken, record what it yields
    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input logic typed, input jcs_pkg::result_t typed_res);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= fin;
        do
            @(posedge clk);
        while (!in_if.ready);
        strip_step(b, fin);
        if (typed)
            stripped_q.push_back(typed_res);
        else
            foreach (step_out[i])
                stripped_q.push_back(step_out[i]);
    endtask

    task automatic wait_drained();
        while (stripped_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_noise();
        if ($urandom_range(0, 3) == 0)
            burst.push_back(jcs_pkg::MARK_PREFIX);
        else
            burst.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_marker(input logic [7:0] code);
        burst.push_back(jcs_pkg::MARK_PREFIX);
        burst.push_back(code);
    endfunction

    // Build one codestream: mostly header plus comment with random content,
    // some pure noise, some with the comment out of place or repeated
    function automatic void make_stream();
        int kind;
        int len_pick;
        logic [15:0] seg_len;
        burst.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_noise();
            return;
        end
        repeat ($urandom_range(0, 2))
            push_noise();
        if (kind == 1)
        begin
            push_marker(jcs_pkg::MARK_COM);
            burst.push_back(8'($urandom_range(0, 255)));
            burst.push_back(8'($urandom_range(0, 255)));
        end
        push_marker(jcs_pkg::MARK_SOC);
        repeat ($urandom_range(0, 3))
            push_noise();
        if (kind == 2)
            push_marker($urandom_range(0, 1) ? jcs_pkg::MARK_SOT : jcs_pkg::MARK_EOC);
        push_marker(jcs_pkg::MARK_COM);
        len_pick = $urandom_range(0, 7);
        if (len_pick == 0)
            seg_len = 16'hffff;
        else if (len_pick == 1)
            seg_len = 16'($urandom_range(0, 16'hffff));
        else
            seg_len = 16'($urandom_range(0, 6));
        burst.push_back(seg_len[15:8]);
        burst.push_back(seg_len[7:0]);
        if (seg_len <= 6)
        begin
            repeat ((seg_len > 2) ? seg_len - 2 : 0)
                burst.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4))
                push_noise();
            if (kind == 3)
            begin
                push_marker(jcs_pkg::MARK_COM);
                burst.push_back(8'($urandom_range(0, 255)));
                burst.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // stream ends inside the comment
            repeat ($urandom_range(0, 5))
                burst.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Receiver stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        jcs_pkg::result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (stripped_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result expected none actual %h/%b/%b",
                         $time, out_if.out_byte, out_if.byte_valid,
                         out_if.end_of_stream);
            end
            else
            begin
                want = stripped_q.pop_front();
                if (out_if.out_byte !== want.out_byte)
                begin
                    fail_count++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, out_if.out_byte);
                end
                if (out_if.byte_valid !== want.byte_valid)
                begin
                    fail_count++;
                    $display("%0t: byte_valid expected %b actual %b",
                             $time, want.byte_valid, out_if.byte_valid);
                end
                if (out_if.end_of_stream !== want.end_of_stream)
                begin
                    fail_count++;
                    $display("%0t: end_of_stream expected %b actual %b",
                             $time, want.end_of_stream, out_if.end_of_stream);
                end
            end
        end
    end

    initial
    begin
        int ph;
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        fail_count = 0;
        rand_sent = 0;
        src_idle_pct = 23;
        snk_idle_pct = 65;
        clear_predictor();

        // hold reset, then release
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIRECTED[r].data_byte, DIRECTED[r].last_byte,
                      DIRECTED[r].exp_typed, DIRECTED[r].exp_res);

        // random streams in three idling phases; drain before each phase
        for (ph = 0; ph < 3; ph++)
        begin
            in_if.valid <= 1'b0;
            wait_drained();
            src_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 65 : 0;
            snk_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 23 : 0;
            while (rand_sent < (ph + 1) * RAND_ITEMS / 3)
            begin
                make_stream();
                foreach (burst[i])
                begin
                    send_byte(burst[i], i == burst.size() - 1, 1'b0, '0);
                    rand_sent++;
                end
            end
        end

        // wait for the tail, then give the verdict
        in_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
